// ----- src/opcp_pkg.sv -----
package opcp_pkg;

  localparam int SamplesDef = 60;

  localparam int TickW  = 16;
  localparam int IdxW   = 8;
  localparam int StepW  = 8;
  localparam int TimeW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [TickW-1:0] HighUs    = 16'd100;
  localparam logic [TickW-1:0] RecoverUs = 16'd500;

  localparam logic [TimeW-1:0] ResetTimeDef = 16'd500;
  localparam logic [StepW-1:0] StepDef      = 8'd5;
  localparam logic [TimeW-1:0] StartMinDef  = 16'd10;
  localparam logic [TimeW-1:0] StartMaxDef  = 16'd80;
  localparam logic [TimeW-1:0] WidthMinDef  = 16'd50;
  localparam logic [TimeW-1:0] WidthMaxDef  = 16'd260;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HIGH    = 3'd1,
    PH_LOW     = 3'd2,
    PH_SAMPLE  = 3'd3,
    PH_RECOVER = 3'd4
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_TIME = 3'd0,
    REG_SAMPLE_STEP = 3'd1,
    REG_START_MIN  = 3'd2,
    REG_START_MAX  = 3'd3,
    REG_WIDTH_MIN  = 3'd4,
    REG_WIDTH_MAX  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [TimeW-1:0] reset_time_us;
    logic [StepW-1:0] step_len_us;
    logic [TimeW-1:0] start_min_us;
    logic [TimeW-1:0] start_max_us;
    logic [TimeW-1:0] width_min_us;
    logic [TimeW-1:0] width_max_us;
  } cfg_t;

  typedef struct packed {
    logic             timing_ok;
    logic [TimeW-1:0] pulse_width_us;
    logic [TimeW-1:0] pulse_start_us;
    logic [IdxW-1:0]  low_samples;
    logic             present;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } res_t;

  localparam int ResW = $bits(res_t);
  localparam int OutDataW = ((ResW + 7) / 8) * 8;

endpackage

// ----- src/opcp_cfg.sv -----
module opcp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [opcp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [opcp_pkg::CfgDataW-1:0] cfg_wdata,
  output opcp_pkg::cfg_t                cfg
);

  opcp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_time_us  <= opcp_pkg::ResetTimeDef;
      cfg_r.step_len_us    <= opcp_pkg::StepDef;
      cfg_r.start_min_us   <= opcp_pkg::StartMinDef;
      cfg_r.start_max_us   <= opcp_pkg::StartMaxDef;
      cfg_r.width_min_us   <= opcp_pkg::WidthMinDef;
      cfg_r.width_max_us   <= opcp_pkg::WidthMaxDef;
    end else if (cfg_we) begin
      case (cfg_index)
        opcp_pkg::REG_RESET_TIME:  cfg_r.reset_time_us  <= cfg_wdata;
        opcp_pkg::REG_SAMPLE_STEP: cfg_r.step_len_us    <= cfg_wdata[opcp_pkg::StepW-1:0];
        opcp_pkg::REG_START_MIN:   cfg_r.start_min_us   <= cfg_wdata;
        opcp_pkg::REG_START_MAX:   cfg_r.start_max_us   <= cfg_wdata;
        opcp_pkg::REG_WIDTH_MIN:   cfg_r.width_min_us   <= cfg_wdata;
        opcp_pkg::REG_WIDTH_MAX:   cfg_r.width_max_us   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/opcp_seq.sv -----
module opcp_seq #(
  parameter int SAMPLES = opcp_pkg::SamplesDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           cmd,
  input  logic           line_level,
  input  opcp_pkg::cfg_t cfg,
  output opcp_pkg::res_t res
);

  localparam logic [opcp_pkg::IdxW-1:0] LastIdx = opcp_pkg::IdxW'(SAMPLES);

  opcp_pkg::phase_t phase_r, phase_nxt;
  logic [opcp_pkg::TickW-1:0] tick_r, tick_nxt, tick_inc;
  logic [opcp_pkg::IdxW-1:0]  idx_r, idx_nxt, idx_inc;
  logic [opcp_pkg::IdxW-1:0]  low_r, low_nxt;
  logic [opcp_pkg::IdxW-1:0]  first_r, first_nxt;
  logic [opcp_pkg::IdxW-1:0]  last_r, last_nxt;
  logic                       seen_r, seen_nxt;
  logic                       step_end, done;

  logic [opcp_pkg::IdxW:0]        span;
  logic [2*opcp_pkg::IdxW-1:0]    start_prod;
  logic [2*opcp_pkg::IdxW:0]      width_prod;
  logic [opcp_pkg::StepW-1:0]     step;
  logic [opcp_pkg::TimeW-1:0]     start_us, width_val;

  assign tick_inc = tick_r + 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign step_end = tick_inc >= {{(opcp_pkg::TickW-opcp_pkg::StepW){1'b0}}, cfg.step_len_us};

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    done      = 1'b0;
    if (cmd) begin
      if (phase_r == opcp_pkg::PH_IDLE) phase_nxt = opcp_pkg::PH_HIGH;
    end else begin
      case (phase_r)
        opcp_pkg::PH_IDLE: phase_nxt = opcp_pkg::PH_IDLE;
        opcp_pkg::PH_HIGH: begin
          if (tick_inc >= opcp_pkg::HighUs) phase_nxt = opcp_pkg::PH_LOW;
        end
        opcp_pkg::PH_LOW: begin
          if (tick_inc == '0 || tick_inc >= cfg.reset_time_us) phase_nxt = opcp_pkg::PH_SAMPLE;
        end
        opcp_pkg::PH_SAMPLE: begin
          if (step_end && (idx_inc >= LastIdx || idx_inc == '0)) begin
            phase_nxt = opcp_pkg::PH_RECOVER;
          end
        end
        opcp_pkg::PH_RECOVER: begin
          if (tick_inc >= opcp_pkg::RecoverUs) begin
            phase_nxt = opcp_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
        default: phase_nxt = opcp_pkg::PH_IDLE;
      endcase
    end
  end

  // Counters and the low-sample bookkeeping.
  always_comb begin
    tick_nxt  = tick_r;
    idx_nxt   = idx_r;
    low_nxt   = low_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    if (cmd) begin
      if (phase_r == opcp_pkg::PH_IDLE) begin
        tick_nxt  = '0;
        idx_nxt   = '0;
        low_nxt   = '0;
        first_nxt = '0;
        last_nxt  = '0;
        seen_nxt  = 1'b0;
      end
    end else begin
      case (phase_r)
        opcp_pkg::PH_IDLE: tick_nxt = tick_r;
        opcp_pkg::PH_SAMPLE: begin
          if (tick_r == '0 && !line_level) begin
            low_nxt  = low_r + 1'b1;
            if (!seen_r) first_nxt = idx_r;
            last_nxt = idx_r;
            seen_nxt = 1'b1;
          end
          if (step_end) begin
            tick_nxt = '0;
            idx_nxt  = idx_inc;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        opcp_pkg::PH_HIGH, opcp_pkg::PH_LOW, opcp_pkg::PH_RECOVER: begin
          tick_nxt = (phase_nxt != phase_r) ? '0 : tick_inc;
        end
        default: tick_nxt = '0;
      endcase
    end
  end

  // Report; first and last index do not move during recovery.
  assign step       = (cfg.step_len_us == '0) ? 8'd1 : cfg.step_len_us;
  assign span       = {1'b0, last_r} + 1'b1 - {1'b0, first_r};
  assign start_prod = first_r * step;
  assign width_prod = span * step;
  assign start_us   = start_prod;
  assign width_val  = width_prod[2*opcp_pkg::IdxW] ? '1 : width_prod[opcp_pkg::TimeW-1:0];

  always_comb begin
    res           = '0;
    res.drive_low = (phase_nxt == opcp_pkg::PH_LOW);
    res.busy_res  = (phase_nxt != opcp_pkg::PH_IDLE);
    res.done_res  = done;
    if (done && seen_r) begin
      res.present        = 1'b1;
      res.low_samples    = low_r;
      res.pulse_start_us = start_us;
      res.pulse_width_us = width_val;
      res.timing_ok      = start_us >= cfg.start_min_us && start_us <= cfg.start_max_us &&
                           width_val >= cfg.width_min_us && width_val <= cfg.width_max_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= opcp_pkg::PH_IDLE;
      tick_r  <= '0;
      idx_r   <= '0;
      low_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      low_r   <= low_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ----- src/onewire_presence_pulse_checker.sv -----
// An accepted item goes to the input register, then its result to the result register;
// a stalled output holds it in the input register. Throughput: one item per cycle while
// the output is not stalled; the probe state updates once per item in one pass.
// Reset (rst_n low, synchronous): the probe returns to idle, counters clear, both
// stages empty, and the configuration registers take their default values.
module onewire_presence_pulse_checker #(
  parameter int SAMPLES = opcp_pkg::SamplesDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] line_level, rest zero
  input  logic                           in_tuser,   // [0] cmd (1 starts a probe)
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] present, [11:4] low_samples,
  // [27:12] pulse_start_us, [43:28] pulse_width_us, [44] timing_ok, rest zero
  output logic [opcp_pkg::OutDataW-1:0]  out_tdata,
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [opcp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [opcp_pkg::CfgDataW-1:0]  cfg_wdata
);

  // The input register holds one item; it is processed in the cycle in which the
  // result register is empty or being drained, so both sides stream without bubbles.
  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_cmd_r, s1_line_r;
  logic           out_valid_r, out_valid_nxt;
  opcp_pkg::res_t out_res_r;
  opcp_pkg::res_t res;
  opcp_pkg::cfg_t cfg;
  logic           adv;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  opcp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sequencer keeps the probe state and forms the result of the held item.
  opcp_seq #(
    .SAMPLES (SAMPLES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cmd        (s1_cmd_r),
    .line_level (s1_line_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (adv)               s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv)             out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_line_r <= in_tdata[0];
    end
    if (adv) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(opcp_pkg::OutDataW-opcp_pkg::ResW){1'b0}}, out_res_r};

  // A report only appears at the end of a probe, never while it is still running.
  a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1] && !out_tdata[0])
    else $error("report item while probe still busy");

  // Presence is reported only with the done flag.
  a_present_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("presence flagged outside a report");

  // Timing can only pass when a device answered.
  a_ok_present : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44] |-> out_tdata[3])
    else $error("timing_ok without presence");

  // A held result stays put until the output side takes it.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tvalid && !out_tready) |-> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

endmodule
